// ===== src/mfh_pkg.sv =====
// mfh_pkg: shared types, result codes and the QoS decode for the MQTT
// fixed-header deframer. No dependencies.
package mfh_pkg;

    localparam int LEN_W       = 28;
    localparam int QUEUE_DEPTH = 2;

    // result kind codes
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // MQTT control packet type nibbles
    localparam logic [3:0] PKT_PUBLISH = 4'd3;
    localparam logic [3:0] PKT_PUBACK  = 4'd4;
    localparam logic [3:0] PKT_PUBREC  = 4'd5;
    localparam logic [3:0] PKT_PUBREL  = 4'd6;
    localparam logic [3:0] PKT_PUBCOMP = 4'd7;

    localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
    localparam logic [7:0] QOS_MASK      = 8'h06;
    localparam logic [2:0] MAX_GROUPS    = 3'd4;

    // one result word as it travels from the parser to the output stage
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       type_flags;
        logic [LEN_W-1:0] remaining_length;
        logic [7:0]       payload_byte;
        logic             last;
    } mfh_rec_t;

    function automatic logic [1:0] qos_of(input logic [7:0] t);
        logic [7:0] q;
        q = t & QOS_MASK;
        case (t[7:4])
            PKT_PUBLISH:                        qos_of = q[2:1];
            PKT_PUBACK:                         qos_of = 2'd1;
            PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP: qos_of = 2'd2;
            default:                            qos_of = 2'd0;
        endcase
    endfunction

endpackage

// ===== src/mfh_front.sv =====
// mfh_front: byte classifier and remaining-length parser. Tracks the packet
// phase and pushes header, payload and error words. Uses mfh_pkg.
module mfh_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       stream_byte,
    output logic             push,
    output mfh_pkg::mfh_rec_t rec
);
    import mfh_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       held_reg, held_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic [2:0]       group_reg, group_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic             push_next;
    mfh_rec_t         rec_next;

    logic [LEN_W-1:0] group_bits;
    logic [LEN_W-1:0] accum_sum;
    logic [LEN_W-1:0] left_dec;
    logic [7:0]       data7;

    always_comb
    begin
        data7 = stream_byte & LEN_DATA_MASK;
        case (group_reg[1:0])
            2'd0:    group_bits = {20'd0, data7};
            2'd1:    group_bits = {13'd0, data7, 7'd0};
            2'd2:    group_bits = {6'd0, data7, 14'd0};
            default: group_bits = {data7[6:0], 21'd0};
        endcase
        accum_sum = accum_reg + group_bits;
        left_dec  = left_reg - LEN_W'(1);
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        accum_next = accum_reg;
        group_next = group_reg;
        left_next  = left_reg;
        push_next  = 1'b0;
        rec_next   = '{kind: KIND_HEADER, type_flags: held_reg,
                       remaining_length: '0, payload_byte: 8'd0, last: 1'b0};
        if (take)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (group_reg >= MAX_GROUPS)
                    begin
                        // fifth length byte: report and resync
                        push_next     = 1'b1;
                        rec_next.kind = KIND_ERROR;
                        rec_next.last = 1'b1;
                        phase_next    = PH_TYPE;
                        group_next    = 3'd0;
                        accum_next    = '0;
                    end
                    else
                    begin
                        accum_next = accum_sum;
                        group_next = group_reg + 3'd1;
                        if (!stream_byte[7])
                        begin
                            push_next = 1'b1;
                            rec_next.remaining_length = accum_sum;
                            if (accum_sum == '0)
                            begin
                                rec_next.last = 1'b1;
                                phase_next    = PH_TYPE;
                            end
                            else
                            begin
                                left_next  = accum_sum;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    left_next                 = left_dec;
                    push_next                 = 1'b1;
                    rec_next.kind             = KIND_PAYLOAD;
                    rec_next.remaining_length = accum_reg;
                    rec_next.payload_byte     = stream_byte;
                    rec_next.last             = (left_dec == '0);
                    if (left_dec == '0)
                        phase_next = PH_TYPE;
                end
                default:
                begin
                    held_next  = stream_byte;
                    accum_next = '0;
                    group_next = 3'd0;
                    left_next  = '0;
                    phase_next = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            held_reg  <= 8'd0;
            accum_reg <= '0;
            group_reg <= 3'd0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            accum_reg <= accum_next;
            group_reg <= group_next;
            left_reg  <= left_next;
        end
    end

    assign push = push_next;
    assign rec  = rec_next;

endmodule

// ===== src/mfh_queue.sv =====
// mfh_queue: small register FIFO of result words between the parser and
// the output stage. Uses mfh_pkg.
module mfh_queue #(
    parameter int DEPTH = mfh_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfh_pkg::mfh_rec_t wr_rec,
    input  logic              pop,
    output mfh_pkg::mfh_rec_t rd_rec,
    output logic              not_empty,
    output logic              full
);
    import mfh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    mfh_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

    assign rd_rec    = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== src/mfh_back.sv =====
// mfh_back: output register stage. Pulls words from the queue, decodes QoS
// from the type byte and holds the result under stall. Uses mfh_pkg.
module mfh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mfh_pkg::mfh_rec_t q_rec,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        type_flags,
    output logic [27:0]       remaining_length,
    output logic [1:0]        qos_level,
    output logic [7:0]        payload_byte,
    output logic              last
);
    import mfh_pkg::*;

    logic       valid_reg, valid_next;
    logic       load;
    mfh_rec_t   rec_reg;
    logic [1:0] qos_reg, qos_next;

    assign load       = q_valid && (!valid_reg || !out_stall);
    assign valid_next = (!valid_reg || !out_stall) ? q_valid : valid_reg;
    // error words carry no QoS
    assign qos_next   = (q_rec.kind == KIND_ERROR) ? 2'd0 : qos_of(q_rec.type_flags);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= q_rec;
            qos_reg <= qos_next;
        end
    end

    assign q_pop            = load;
    assign out_valid        = valid_reg;
    assign kind             = rec_reg.kind;
    assign type_flags       = rec_reg.type_flags;
    assign remaining_length = rec_reg.remaining_length;
    assign qos_level        = qos_reg;
    assign payload_byte     = rec_reg.payload_byte;
    assign last             = rec_reg.last;

endmodule

// ===== src/mqtt_fixed_header_deframer.sv =====
// Top level of the MQTT fixed-header deframer: mfh_front, mfh_queue, mfh_back; uses mfh_pkg.
// Path: a word enters the queue at the edge that accepts its byte; the output register
//   then loads it from the queue when that register is empty or not stalled.
// Throughput: one byte per cycle while not stalled; type and continued length bytes give
//   no word. A two-word queue absorbs output stalls; in_stall is high only while it is full.
// Reset: rst_n, asynchronous; parser awaits a type byte, queue and output are emptied.
module mqtt_fixed_header_deframer #(
    parameter int QUEUE_DEPTH = mfh_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  type_flags,
    output logic [27:0] remaining_length,
    output logic [1:0]  qos_level,
    output logic [7:0]  payload_byte,
    output logic        last
);
    import mfh_pkg::*;

    logic     take;
    logic     push;
    logic     pop;
    logic     q_not_empty;
    logic     q_full;
    mfh_rec_t front_rec;
    mfh_rec_t queue_rec;

    // Front only runs when the queue has room, so a word is never dropped.
    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    // Parser: type byte, 1..4 length groups, body count-down.
    mfh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (stream_byte),
        .push        (push),
        .rec         (front_rec)
    );

    mfh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_rec    (front_rec),
        .pop       (pop),
        .rd_rec    (queue_rec),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Output stage: registered result, QoS decoded on the way in.
    mfh_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_not_empty),
        .q_rec            (queue_rec),
        .q_pop            (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .type_flags       (type_flags),
        .remaining_length (remaining_length),
        .qos_level        (qos_level),
        .payload_byte     (payload_byte),
        .last             (last)
    );

    // Error words always close the packet and carry no length or QoS.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> last && remaining_length == '0
                                            && qos_level == 2'd0)
        else $error("error word malformed");

    // A header is last exactly when its length is zero.
    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HEADER |-> last == (remaining_length == '0))
        else $error("header last flag disagrees with length");

    // Payload words never report a zero length.
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PAYLOAD |-> remaining_length != '0)
        else $error("payload word with zero length");

    // No unused kind code reaches the outputs.
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_HEADER || kind == KIND_PAYLOAD
                      || kind == KIND_ERROR)
        else $error("bad kind code");

endmodule

// ===== verif/mqtt_fixed_header_deframer_test.sv =====
// Self-checking testbench for mqtt_fixed_header_deframer: drives packet byte
// streams, predicts header, payload and length-error words, checks each one.
// Depends on mfh_pkg and the deframer RTL only.
module mqtt_fixed_header_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mfh_pkg::*;

    // parser position inside the current packet
    typedef enum logic [1:0] {AWAIT_TYPE, AWAIT_LENGTH, IN_BODY} parse_phase_t;

    // receiver behavior on out_stall
    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // one output word as the checker sees it
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  type_flags;
        logic [27:0] remaining_length;
        logic [1:0]  qos_level;
        logic [7:0]  payload_byte;
        logic        last;
    } frame_word_t;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_LIMIT  = 20000; // cycles allowed for the final drain
    localparam int TAIL_CYCLES  = 8;     // covers the queue and output register, plus margin
    localparam int RANDOM_BYTES = 450;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  type_flags;
    logic [27:0] remaining_length;
    logic [1:0]  qos_level;
    logic [7:0]  payload_byte;
    logic        last;

    // predicted parser state, tracked per accepted byte
    parse_phase_t prs_phase  = AWAIT_TYPE;
    logic [7:0]   prs_type   = '0;
    logic [27:0]  prs_length = '0;
    logic [2:0]   prs_groups = '0;
    logic [27:0]  prs_left   = '0;

    // words predicted but not yet seen on the output
    frame_word_t pending_words[$];

    // sender pacing
    bit       gaps_on    = 1'b1;
    int       burst_left = 0;

    // receiver pacing; hold_request starts one long hold-off
    rx_mode_t rx_mode      = RX_RANDOM;
    bit       hold_request = 1'b0;
    int       hold_left    = 0;
    int       rx_step      = 0;

    // tallies
    int mismatches       = 0;
    int bytes_sent       = 0;
    int held_off_cycles  = 0;
    int headers_seen     = 0;
    int payloads_seen    = 0;
    int len_errors_seen  = 0;

    mqtt_fixed_header_deframer DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .stream_byte      (stream_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .type_flags       (type_flags),
        .remaining_length (remaining_length),
        .qos_level        (qos_level),
        .payload_byte     (payload_byte),
        .last             (last)
    );

    always #5 clk = ~clk;

    // Overall run limit.
    initial
    begin
        #2_000_000;
        $display("TIMEOUT at %0t", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // QoS follows the standard control packet types: PUBLISH carries it in
    // flags bits 2:1, PUBACK implies 1, the PUBREC/PUBREL/PUBCOMP leg implies 2.
    function automatic logic [1:0] qos_for_type(input logic [7:0] t);
        case (t[7:4])
            PKT_PUBLISH:                         return t[2:1];
            PKT_PUBACK:                          return 2'd1;
            PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP: return 2'd2;
            default:                             return 2'd0;
        endcase
    endfunction

    // Appends one predicted word at the tail of the pending list.
    function automatic void expect_word(input frame_word_t w);
        pending_words = {pending_words, w};
    endfunction

    // Advances the predicted parser by one accepted byte and queues the word
    // that byte produces, if any.
    function automatic void deframe_byte(input logic [7:0] b);
        frame_word_t w;
        logic [27:0] group_bits;
        w                  = '0;
        w.type_flags       = prs_type;
        w.qos_level        = qos_for_type(prs_type);
        case (prs_phase)
            AWAIT_LENGTH:
            begin
                if (prs_groups >= MAX_GROUPS)
                begin
                    // a fifth length byte aborts the packet, whatever its bit 7
                    w.kind      = KIND_ERROR;
                    w.qos_level = 2'd0;
                    w.last      = 1'b1;
                    expect_word(w);
                    prs_phase  = AWAIT_TYPE;
                    prs_groups = '0;
                    prs_length = '0;
                end
                else
                begin
                    group_bits = 28'(b & LEN_DATA_MASK);
                    prs_length = prs_length + (group_bits << (7 * prs_groups));
                    prs_groups = prs_groups + 3'd1;
                    if (!b[7])
                    begin
                        w.kind             = KIND_HEADER;
                        w.remaining_length = prs_length;
                        w.last             = (prs_length == 0);
                        prs_phase          = (prs_length == 0) ? AWAIT_TYPE : IN_BODY;
                        prs_left           = prs_length;
                        expect_word(w);
                    end
                end
            end
            IN_BODY:
            begin
                prs_left           = prs_left - 28'd1;
                w.kind             = KIND_PAYLOAD;
                w.remaining_length = prs_length;
                w.payload_byte     = b;
                w.last             = (prs_left == 0);
                expect_word(w);
                if (prs_left == 0)
                    prs_phase = AWAIT_TYPE;
            end
            default:
            begin
                prs_type   = b;
                prs_length = '0;
                prs_groups = '0;
                prs_left   = '0;
                prs_phase  = AWAIT_LENGTH;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one byte and waits for it to be taken. When gaps are on, the
    // sender works in bursts with idle cycles between them; stream_byte
    // wanders while valid is low to show it is ignored.
    task automatic send_byte(input logic [7:0] b);
        int pause;
        if (gaps_on && burst_left == 0)
        begin
            pause = $urandom_range(1, 6);
            repeat (pause)
            begin
                @(negedge clk);
                in_valid    <= 1'b0;
                stream_byte <= 8'($urandom);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        stream_byte <= b;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
            held_off_cycles++;
        end
        bytes_sent++;
        deframe_byte(b);
    endtask

    // Sends a full packet: type byte, length groups (minimal plus pad extra
    // zero groups, at most four in all) and len random body bytes.
    task automatic send_packet(input logic [7:0] t, input int len, input int pad);
        int         groups;
        int         rest;
        int         i;
        logic [7:0] b;
        groups = 1;
        rest   = len >> 7;
        while (rest > 0)
        begin
            groups++;
            rest = rest >> 7;
        end
        groups = (groups + pad > 4) ? 4 : groups + pad;
        send_byte(t);
        for (i = 0; i < groups; i++)
        begin
            b    = 8'((len >> (7 * i)) & 'h7F);
            b[7] = (i < groups - 1);
            send_byte(b);
        end
        repeat (len)
            send_byte(8'($urandom));
    endtask

    // Four continued length bytes followed by a fifth: the fifth draws an
    // error word and the parser goes back to looking for a type byte.
    task automatic send_bad_length(input logic [7:0] t, input logic [7:0] fifth);
        send_byte(t);
        repeat (4)
            send_byte(8'h80 | 8'($urandom_range(0, 127)));
        send_byte(fifth);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // out_stall changes on the falling edge. A hold-off request overrides the
    // current pattern; hold_left counts the hold-off down from HOLD_CYCLES.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    // stalled while rx_step, counting modulo 7, is below 3
                    rx_step    = (rx_step + 1) % 7;
                    out_stall <= (rx_step < 3);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic log_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Every word taken by the receiver is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_words
        frame_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            case (kind)
                KIND_HEADER:  headers_seen++;
                KIND_PAYLOAD: payloads_seen++;
                KIND_ERROR:   len_errors_seen++;
                default:      ;
            endcase
            if (pending_words.size() == 0)
                log_mismatch($sformatf("unexpected word kind=%0d type=%02h len=%0d",
                                       kind, type_flags, remaining_length));
            else
            begin
                want = pending_words.pop_front();
                if (kind !== want.kind)
                    log_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (type_flags !== want.type_flags)
                    log_mismatch($sformatf("type_flags %02h, want %02h",
                                           type_flags, want.type_flags));
                if (remaining_length !== want.remaining_length)
                    log_mismatch($sformatf("remaining_length %0d, want %0d",
                                           remaining_length, want.remaining_length));
                if (qos_level !== want.qos_level)
                    log_mismatch($sformatf("qos_level %0d, want %0d",
                                           qos_level, want.qos_level));
                if (payload_byte !== want.payload_byte)
                    log_mismatch($sformatf("payload_byte %02h, want %02h",
                                           payload_byte, want.payload_byte));
                if (last !== want.last)
                    log_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One packet of each QoS-relevant type, zero-length packets included.
    task automatic test_packet_types();
        send_packet(8'hC0, 0, 0);   // PINGREQ, header is last
        send_packet(8'h3B, 2, 0);   // PUBLISH, QoS from flags = 1
        send_packet(8'h36, 1, 0);   // PUBLISH, flags give 3
        send_packet(8'h40, 0, 0);   // PUBACK
        send_packet(8'h52, 0, 0);   // PUBREC
        send_packet(8'h62, 0, 0);   // PUBREL
        send_packet(8'h7F, 0, 0);   // PUBCOMP with odd flags
    endtask

    // Padded encodings, and the fifth length byte with bit 7 clear and set.
    task automatic test_length_encoding();
        send_packet(8'hE0, 0, 3);   // 80 80 80 00 decodes to zero
        send_packet(8'h21, 1, 2);   // 81 80 00 decodes to one
        send_bad_length(8'h82, 8'h00);
        send_bad_length(8'h90, 8'hFF);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering bytes; the output queue fills and in_stall must rise.
    task automatic test_backpressure();
        gaps_on      = 1'b0;
        rx_mode      = RX_FREE;
        hold_request = 1'b1;
        repeat (4)
            send_packet(8'h30 | 8'($urandom_range(0, 15)), $urandom_range(6, 12), 0);
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
    endtask

    // Mostly well-formed packets with random types and bodies; some padded
    // encodings, some aborted by a fifth length byte. Pacing on both sides
    // is reshuffled now and then, including stretches with no gaps at all.
    task automatic test_random_traffic();
        int start;
        int pick;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            end
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 200)
                                                : $urandom_range(0, 24);
            if (pick < 80)
                send_packet(8'($urandom), len, 0);
            else if (pick < 90)
                send_packet(8'($urandom), len, $urandom_range(1, 3));
            else
                send_bad_length(8'($urandom), 8'($urandom));
        end
    endtask

    // Largest length the four groups can carry. The body is far too long to
    // send, so this runs last and leaves the parser mid-body.
    task automatic test_longest_length();
        rx_mode = RX_RANDOM;
        send_byte(8'h3F);
        repeat (3)
            send_byte(8'hFF);
        send_byte(8'h7F);
        repeat (6)
            send_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        int waited;
        in_valid    = 1'b0;
        stream_byte = '0;
        rst_n       = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_packet_types();
        test_length_encoding();
        test_backpressure();
        test_random_traffic();
        test_longest_length();

        @(negedge clk);
        in_valid <= 1'b0;

        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_words.size() != 0)
            log_mismatch($sformatf("%0d predicted words never arrived",
                                   pending_words.size()));

        $display("Sent %0d bytes; checked %0d headers, %0d payload bytes, %0d length errors.",
                 bytes_sent, headers_seen, payloads_seen, len_errors_seen);
        $display("Input was held off for %0d cycles; %0d mismatches.",
                 held_off_cycles, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== mqtt_fixed_header_deframer.f =====
src/mfh_pkg.sv
src/mfh_front.sv
src/mfh_queue.sv
src/mfh_back.sv
src/mqtt_fixed_header_deframer.sv
verif/mqtt_fixed_header_deframer_test.sv
